// ===== rtl/core/pmkt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmkt_pkg
// shared constants and the table row layout for the priority masked keymap
// table
// ----------------------------------------------------------------------------
`default_nettype none

package pmkt_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_W      = 16;
    localparam int WORD_W     = 64;
    localparam int MASK_WORDS = 4;
    localparam int MASK_W     = WORD_W * MASK_WORDS;
    localparam int WEIGHT_W   = 10;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = $clog2(BYTE_W + 1);
    localparam int REQ_W      = 2 * MASK_W;
    localparam int BYTES      = REQ_W / BYTE_W;
    localparam int BYTE_IDX_W = $clog2(BYTES);
    localparam int ENTRY_AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W    = $clog2(ENTRIES + 1);

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]    in_key;
        logic [KEY_W-1:0]    out_key;
        logic [WEIGHT_W-1:0] weight;
        logic [MASK_W-1:0]   mod_mask;
        logic [MASK_W-1:0]   lock_mask;
    } pmkt_entry_t;

    localparam int ROW_W = $bits(pmkt_entry_t);

endpackage

`default_nettype wire

// ===== rtl/core/pmkt_ram.sv =====
// ----------------------------------------------------------------------------
// pmkt_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pmkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pmkt_weight.sv =====
// ----------------------------------------------------------------------------
// pmkt_weight
// serial specificity counter: counts set bits of both required masks, one
// byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pmkt_weight (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [pmkt_pkg::REQ_W-1:0]     req_mask,
    output logic                                done,
    output logic      [pmkt_pkg::WEIGHT_W-1:0]  weight
);

    import pmkt_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [WEIGHT_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]     cur_byte;
    logic [CNT_W-1:0]      byte_cnt;

    assign cur_byte = req_mask[byte_idx_reg*BYTE_W +: BYTE_W];

    // popcount of one byte
    always_comb begin
        byte_cnt = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            byte_cnt = byte_cnt + CNT_W'(cur_byte[i]);
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        byte_idx_next = byte_idx_reg;
        acc_next      = acc_reg;
        if (start) begin
            busy_next     = 1'b1;
            byte_idx_next = '0;
            acc_next      = '0;
        end else if (busy_reg) begin
            acc_next      = acc_reg + WEIGHT_W'(byte_cnt);
            byte_idx_next = byte_idx_reg + BYTE_IDX_W'(1);
            if (byte_idx_reg == BYTE_IDX_W'(BYTES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            byte_idx_reg <= '0;
        end else begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            byte_idx_reg <= byte_idx_next;
        end
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign weight = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/priority_masked_keymap_table_unit.sv =====
// ----------------------------------------------------------------------------
// priority_masked_keymap_table_unit
// key remapping table: inserts append entries, lookups return the output key
// of the most specific matching entry, earliest insert winning ties
// ----------------------------------------------------------------------------
// insert: the result word waits on the byte-serial specificity counter
//   (64 bytes of required mask, one per cycle)
// dropped insert on a full table and lookup on an empty table: straight to ST_RESP
// lookup: one ram read per entry; one item in flight
// reset clears the entry count and control state but not the ram; ram contents
//   are never read before they are written, so no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module priority_masked_keymap_table_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [pmkt_pkg::KEY_W-1:0]    s_key_code,
    input  wire logic [pmkt_pkg::KEY_W-1:0]    s_mapped_key,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word0,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word1,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word2,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word3,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word0,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word1,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word2,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word3,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pmkt_pkg::KEY_W-1:0]    m_result_key,
    output logic                               m_hit,
    output logic                               m_table_full
);

    import pmkt_pkg::*;

    // controller states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WEIGH = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                full_flag_reg, full_flag_next;

    // latched input word
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    mapped_reg;
    logic [MASK_W-1:0]   mod_reg;
    logic [MASK_W-1:0]   lock_reg;

    // compare stage and best-so-far tracking
    logic                rd_valid_reg;
    logic                best_found_reg;
    logic [WEIGHT_W-1:0] best_weight_reg;
    logic [KEY_W-1:0]    best_key_reg;

    // output register
    logic                m_valid_reg;
    logic [KEY_W-1:0]    m_result_key_reg;
    logic                m_hit_reg;
    logic                m_table_full_reg;

    logic                accept;
    logic                table_is_full;
    logic                weight_start;
    logic                weight_done;
    logic [WEIGHT_W-1:0] weight_val;
    logic                ram_we;
    logic                ram_re;
    pmkt_entry_t         wr_row;
    pmkt_entry_t         rd_row;
    logic                row_match;
    logic                take_row;
    logic                load_out;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign table_is_full = (count_reg == COUNT_W'(ENTRIES));
    assign weight_start  = accept && (s_action == ACT_INSERT) && !table_is_full;
    assign load_out      = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    // latch the item at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= s_key_code;
            mapped_reg <= s_mapped_key;
            mod_reg    <= {s_mod_word3, s_mod_word2, s_mod_word1, s_mod_word0};
            lock_reg   <= {s_lock_word3, s_lock_word2, s_lock_word1, s_lock_word0};
        end
    end

    // specificity of the entry being inserted
    pmkt_weight u_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (weight_start),
        .req_mask ({lock_reg, mod_reg}),
        .done     (weight_done),
        .weight   (weight_val)
    );

    // entry write happens once the weight is known
    assign ram_we = (state_reg == ST_WEIGH) && weight_done;
    assign ram_re = (state_reg == ST_SCAN);

    always_comb begin
        wr_row.in_key    = key_reg;
        wr_row.out_key   = mapped_reg;
        wr_row.weight    = weight_val;
        wr_row.mod_mask  = mod_reg;
        wr_row.lock_mask = lock_reg;
    end

    pmkt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ENTRY_AW-1:0]),
        .wr_data (wr_row),
        .rd_en   (ram_re),
        .rd_addr (scan_idx_reg[ENTRY_AW-1:0]),
        .rd_data (rd_row)
    );

    // an entry matches when keys agree and every required bit is active
    assign row_match = (rd_row.in_key == key_reg)
                    && !(|(rd_row.mod_mask & ~mod_reg))
                    && !(|(rd_row.lock_mask & ~lock_reg));

    // strictly greater keeps the earliest entry on equal weight
    assign take_row  = rd_valid_reg && row_match
                    && (!best_found_reg || (rd_row.weight > best_weight_reg));

    // controller
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        full_flag_next = full_flag_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    full_flag_next = 1'b0;
                    if (s_action == ACT_INSERT) begin
                        if (table_is_full) begin
                            full_flag_next = 1'b1;
                            state_next     = ST_RESP;
                        end else begin
                            state_next = ST_WEIGH;
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_RESP;
                    end else begin
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_WEIGH: begin
                if (weight_done) begin
                    count_next = count_reg + COUNT_W'(1);
                    state_next = ST_RESP;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle up to the last written entry
                if (scan_idx_reg + COUNT_W'(1) == count_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + COUNT_W'(1);
                end
            end
            ST_DRAIN: begin
                // last row is compared in this cycle
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            full_flag_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            full_flag_reg <= full_flag_next;
            rd_valid_reg  <= ram_re;
        end
    end

    // best match so far
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (accept) begin
            best_found_reg <= 1'b0;
        end else if (take_row) begin
            best_found_reg <= 1'b1;
        end
        if (take_row) begin
            best_weight_reg <= rd_row.weight;
            best_key_reg    <= rd_row.out_key;
        end
    end

    // output register, freed when the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            m_result_key_reg <= best_found_reg ? best_key_reg : '0;
            m_hit_reg        <= best_found_reg;
            m_table_full_reg <= full_flag_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_result_key = m_result_key_reg;
    assign m_hit        = m_hit_reg;
    assign m_table_full = m_table_full_reg;

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(ENTRIES))
        else $error("entry count above table depth");

    // an entry is only written into free space
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !table_is_full)
        else $error("table write while full");

    // a dropped insert leaves the table untouched
    a_drop_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == ACT_INSERT) && table_is_full) |=> $stable(count_reg))
        else $error("dropped insert changed entry count");

    // a full flag never comes with a match
    a_full_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> (!m_hit && (m_result_key == '0)))
        else $error("table full word carries a match");

endmodule

`default_nettype wire

// ===== test/pmkt_checker.sv =====
// ----------------------------------------------------------------------------
// pmkt_checker
// watches both channels of the keymap table, keeps its own copy of the table,
// works out the answer for every accepted word and compares the result words
// in order
// ----------------------------------------------------------------------------
`default_nettype none

module pmkt_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          s_action,
    input  wire logic [pmkt_pkg::KEY_W-1:0]    s_key_code,
    input  wire logic [pmkt_pkg::KEY_W-1:0]    s_mapped_key,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word0,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word1,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word2,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_mod_word3,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word0,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word1,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word2,
    input  wire logic [pmkt_pkg::WORD_W-1:0]   s_lock_word3,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [pmkt_pkg::KEY_W-1:0]    m_result_key,
    input  wire logic                          m_hit,
    input  wire logic                          m_table_full,
    output int                                 mismatch_count,
    output int                                 words_pending
);

    import pmkt_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] result_key;
        logic             hit;
        logic             table_full;
    } keymap_answer_t;

    pmkt_entry_t          shadow_rows [ENTRIES];
    logic [COUNT_W-1:0]   shadow_count;
    keymap_answer_t       answer_q [$];

    // insert appends a row, lookup picks the heaviest matching row,
    // strict compare so the oldest row keeps a tie
    function automatic keymap_answer_t resolve_word(
        input logic             act,
        input logic [KEY_W-1:0] key,
        input logic [KEY_W-1:0] mapped,
        input logic [MASK_W-1:0] mods,
        input logic [MASK_W-1:0] locks
    );
        keymap_answer_t      ans;
        logic [WEIGHT_W-1:0] best;
        int                  i;
        ans  = '0;
        best = '0;
        if (act == ACT_INSERT) begin
            if (shadow_count >= ENTRIES) begin
                ans.table_full = 1'b1;
            end else begin
                shadow_rows[shadow_count].in_key    = key;
                shadow_rows[shadow_count].out_key   = mapped;
                shadow_rows[shadow_count].mod_mask  = mods;
                shadow_rows[shadow_count].lock_mask = locks;
                shadow_rows[shadow_count].weight    =
                    WEIGHT_W'($countones(mods) + $countones(locks));
                shadow_count = shadow_count + 1'b1;
            end
        end else begin
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_rows[i].in_key == key &&
                    (shadow_rows[i].mod_mask & ~mods) == '0 &&
                    (shadow_rows[i].lock_mask & ~locks) == '0 &&
                    (!ans.hit || shadow_rows[i].weight > best)) begin
                    ans.hit        = 1'b1;
                    ans.result_key = shadow_rows[i].out_key;
                    best           = shadow_rows[i].weight;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        keymap_answer_t want;
        keymap_answer_t next_ans;
        if (!aresetn) begin
            shadow_count = '0;
            answer_q.delete();
            words_pending <= 0;
        end else begin
            // results first, so a word accepted on this edge cannot pair up
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (answer_q.size() == 0) begin
                    $error("result word with nothing pending: %s %h hit %b table_full %b",
                           "result_key", m_result_key, m_hit, m_table_full);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (m_result_key !== want.result_key) begin
                        $error("result_key: expected %h, actual %h",
                               want.result_key, m_result_key);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %b, actual %b", want.hit, m_hit);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_table_full !== want.table_full) begin
                        $error("table_full: expected %b, actual %b",
                               want.table_full, m_table_full);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                next_ans = resolve_word(
                    s_action, s_key_code, s_mapped_key,
                    {s_mod_word3, s_mod_word2, s_mod_word1, s_mod_word0},
                    {s_lock_word3, s_lock_word2, s_lock_word1, s_lock_word0});
                answer_q = {answer_q, next_ans};
            end
            words_pending <= answer_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/priority_masked_keymap_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// priority_masked_keymap_table_unit_tb
// drives inserts and lookups into the keymap table with random gaps on both
// sides; the checker beside the block predicts every result word and the top
// reports the verdict from its mismatch count
// ----------------------------------------------------------------------------
`default_nettype none

module priority_masked_keymap_table_unit_tb;

    import pmkt_pkg::*;

    localparam int RANDOM_WORDS = 930;
    localparam int POOL_KEYS    = 6;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_action;
    logic [KEY_W-1:0]    s_key_code;
    logic [KEY_W-1:0]    s_mapped_key;
    logic [WORD_W-1:0]   s_mod_word0;
    logic [WORD_W-1:0]   s_mod_word1;
    logic [WORD_W-1:0]   s_mod_word2;
    logic [WORD_W-1:0]   s_mod_word3;
    logic [WORD_W-1:0]   s_lock_word0;
    logic [WORD_W-1:0]   s_lock_word1;
    logic [WORD_W-1:0]   s_lock_word2;
    logic [WORD_W-1:0]   s_lock_word3;
    logic                m_valid;
    logic                m_ready;
    logic [KEY_W-1:0]    m_result_key;
    logic                m_hit;
    logic                m_table_full;
    int                  mismatch_count;
    int                  words_pending;

    // both sides stop their random gaps while this is set
    logic                quiet_phase = 1'b0;

    // what has been stored so far, kept only to aim lookups at real rows
    logic [KEY_W-1:0]    stored_key  [ENTRIES];
    logic [MASK_W-1:0]   stored_mod  [ENTRIES];
    logic [MASK_W-1:0]   stored_lock [ENTRIES];
    int                  stored_n = 0;
    logic [KEY_W-1:0]    key_pool    [POOL_KEYS];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    priority_masked_keymap_table_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_key_code   (s_key_code),
        .s_mapped_key (s_mapped_key),
        .s_mod_word0  (s_mod_word0),
        .s_mod_word1  (s_mod_word1),
        .s_mod_word2  (s_mod_word2),
        .s_mod_word3  (s_mod_word3),
        .s_lock_word0 (s_lock_word0),
        .s_lock_word1 (s_lock_word1),
        .s_lock_word2 (s_lock_word2),
        .s_lock_word3 (s_lock_word3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_key (m_result_key),
        .m_hit        (m_hit),
        .m_table_full (m_table_full)
    );

    pmkt_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_key_code     (s_key_code),
        .s_mapped_key   (s_mapped_key),
        .s_mod_word0    (s_mod_word0),
        .s_mod_word1    (s_mod_word1),
        .s_mod_word2    (s_mod_word2),
        .s_mod_word3    (s_mod_word3),
        .s_lock_word0   (s_lock_word0),
        .s_lock_word1   (s_lock_word1),
        .s_lock_word2   (s_lock_word2),
        .s_lock_word3   (s_lock_word3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_key   (m_result_key),
        .m_hit          (m_hit),
        .m_table_full   (m_table_full),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // mostly a few scattered bits, sometimes dense, empty or all set
    function automatic logic [MASK_W-1:0] draw_mask();
        logic [MASK_W-1:0] m;
        int                k;
        int                bits;
        m = '0;
        case ($urandom_range(0, 9))
            0: begin
                for (k = 0; k < MASK_W / 32; k++) m[k*32 +: 32] = $urandom();
            end
            1: m = '1;
            2: m = '0;
            default: begin
                bits = $urandom_range(1, 5);
                for (k = 0; k < bits; k++) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            end
        endcase
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] one_bit(input int pos);
        logic [MASK_W-1:0] m;
        m      = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

    // offer one word after a random gap and hold it until it is taken
    task automatic send_word(
        input logic              act,
        input logic [KEY_W-1:0]  key,
        input logic [KEY_W-1:0]  mapped,
        input logic [MASK_W-1:0] mods,
        input logic [MASK_W-1:0] locks
    );
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action     <= act;
        s_key_code   <= key;
        s_mapped_key <= mapped;
        s_mod_word0  <= mods[0*WORD_W +: WORD_W];
        s_mod_word1  <= mods[1*WORD_W +: WORD_W];
        s_mod_word2  <= mods[2*WORD_W +: WORD_W];
        s_mod_word3  <= mods[3*WORD_W +: WORD_W];
        s_lock_word0 <= locks[0*WORD_W +: WORD_W];
        s_lock_word1 <= locks[1*WORD_W +: WORD_W];
        s_lock_word2 <= locks[2*WORD_W +: WORD_W];
        s_lock_word3 <= locks[3*WORD_W +: WORD_W];
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        // remember stored rows so later lookups can target them
        if (act == ACT_INSERT && stored_n < ENTRIES) begin
            stored_key[stored_n]  = key;
            stored_mod[stored_n]  = mods;
            stored_lock[stored_n] = locks;
            stored_n++;
        end
    endtask

    // result side: random stalls per word, plus two long hold-offs that let
    // the block back up and drop s_ready while the sender keeps offering
    initial begin
        int gap;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == 300 || taken == 650) gap = 500;
            else gap = quiet_phase ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            taken++;
        end
    end

    // hard stop in case the block hangs
    initial begin
        #1200000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int                n;
        int                pick;
        int                row;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mods;
        logic [MASK_W-1:0] locks;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= ACT_LOOKUP;
        s_key_code   <= '0;
        s_mapped_key <= '0;
        s_mod_word0  <= '0;
        s_mod_word1  <= '0;
        s_mod_word2  <= '0;
        s_mod_word3  <= '0;
        s_lock_word0 <= '0;
        s_lock_word1 <= '0;
        s_lock_word2 <= '0;
        s_lock_word3 <= '0;

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h0001;
        key_pool[3] = 16'h0002;
        key_pool[4] = 16'h8000;
        key_pool[5] = 16'h5A5A;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table misses whatever the active state
        send_word(ACT_LOOKUP, 16'h0000, 16'hFFFF, '0, '0);
        send_word(ACT_LOOKUP, 16'hFFFF, 16'h0000, '1, '1);
        // every required bit set gives weight 512, past any 8-bit count
        send_word(ACT_INSERT, 16'hFFFF, 16'hFFFF, '1, '1);
        send_word(ACT_INSERT, 16'hFFFF, 16'h1234, '0, '0);
        send_word(ACT_LOOKUP, 16'hFFFF, 16'h0000, '1, '1);
        // modifiers missing: only the unconditional row matches
        send_word(ACT_LOOKUP, 16'hFFFF, 16'h0000, '0, '1);
        // a hit that maps to key zero still raises hit
        send_word(ACT_INSERT, 16'h0000, 16'h0000, '0, '0);
        send_word(ACT_LOOKUP, 16'h0000, 16'hFFFF, '0, '0);
        // equal weights: the first inserted row wins
        send_word(ACT_INSERT, 16'h0001, 16'h00A1, one_bit(3), '0);
        send_word(ACT_INSERT, 16'h0001, 16'h00A2, '0, one_bit(200));
        send_word(ACT_LOOKUP, 16'h0001, 16'h0000, one_bit(3), one_bit(200));
        send_word(ACT_LOOKUP, 16'h0001, 16'h0000, '0, one_bit(200));
        send_word(ACT_INSERT, 16'h0001, 16'h00A3, one_bit(3) | one_bit(255), '0);
        send_word(ACT_LOOKUP, 16'h0001, 16'h0000, '1, '1);
        // 255 against 256 bits, which would wrap to zero in 8 bits
        send_word(ACT_INSERT, 16'h0002, 16'h00B1, {{(MASK_W-1){1'b1}}, 1'b0}, '0);
        send_word(ACT_INSERT, 16'h0002, 16'h00B2, '1, '0);
        send_word(ACT_LOOKUP, 16'h0002, 16'h0000, '1, '0);
        // key with no row at all
        send_word(ACT_LOOKUP, 16'h0003, 16'h0000, '1, '1);

        // random part: the table fills up early on, after which inserts
        // come back flagged full while lookups keep hitting the stored rows
        for (n = 0; n < RANDOM_WORDS; n++) begin
            quiet_phase <= ((n / 120) % 3) == 1;
            // once mid-run, let the block drain completely
            if (n == RANDOM_WORDS / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (words_pending != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom())
                                                  : key_pool[$urandom_range(0, POOL_KEYS - 1)];
                send_word(ACT_INSERT, key, KEY_W'($urandom()), draw_mask(), draw_mask());
            end else if (pick < 75 && stored_n > 0) begin
                // aim at a stored row with extra bits active, and now and
                // then knock out one bit so a required one may go missing
                row   = $urandom_range(0, stored_n - 1);
                mods  = stored_mod[row] | draw_mask();
                locks = stored_lock[row] | draw_mask();
                if ($urandom_range(0, 4) == 0) mods[$urandom_range(0, MASK_W - 1)] = 1'b0;
                if ($urandom_range(0, 4) == 0) locks[$urandom_range(0, MASK_W - 1)] = 1'b0;
                send_word(ACT_LOOKUP, stored_key[row], KEY_W'($urandom()), mods, locks);
            end else if (pick < 90) begin
                send_word(ACT_LOOKUP, key_pool[$urandom_range(0, POOL_KEYS - 1)],
                          KEY_W'($urandom()), draw_mask(), draw_mask());
            end else begin
                // noise: any key, any active state
                send_word(ACT_LOOKUP, KEY_W'($urandom()), KEY_W'($urandom()),
                          draw_mask(), draw_mask());
            end
        end
        s_valid <= 1'b0;

        // wait out the outstanding words, then a lookup's worth of quiet
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (mismatch_count == 0 && words_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
